// ===== src/rbd_pkg.sv =====
package rbd_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam logic [8:0]  SCREEN_RESET = 9'd256;
	localparam logic [19:0] FRAME_RESET  = 20'd16000;

	localparam logic [2:0] OP_FILL  = 3'd0;
	localparam logic [2:0] OP_COPY  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [8:0]  dst_x;
		logic [8:0]  dst_y;
		logic [8:0]  rect_width;
		logic [8:0]  rect_height;
		logic [8:0]  src_x;
		logic [8:0]  src_y;
		logic [23:0] color;
		logic [47:0] now_us;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [23:0] read_color;
		logic        present;
		logic [8:0]  present_x;
		logic [8:0]  present_y;
		logic [8:0]  present_width;
		logic [8:0]  present_height;
	} rsp_t;

	typedef struct packed {
		logic [8:0]  screen_width;
		logic [8:0]  screen_height;
		logic [19:0] frame_interval_us;
	} cfg_t;

	typedef struct packed {
		logic [8:0] base_x;
		logic [8:0] base_y;
		logic [8:0] off_x;
		logic [8:0] off_y;
	} agu_req_t;

	typedef struct packed {
		logic        we;
		logic        re;
		logic [23:0] wdata;
	} mem_req_t;

endpackage

// ===== src/rbd_cfg.sv =====
module rbd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output rbd_pkg::cfg_t     cfg
);

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FRAME_INTERVAL = 2'd2;

	rbd_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width      <= rbd_pkg::SCREEN_RESET;
			cfg_q.screen_height     <= rbd_pkg::SCREEN_RESET;
			cfg_q.frame_interval_us <= rbd_pkg::FRAME_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SCREEN_WIDTH:   cfg_q.screen_width      <= pwdata[8:0];
				REG_SCREEN_HEIGHT:  cfg_q.screen_height     <= pwdata[8:0];
				REG_FRAME_INTERVAL: cfg_q.frame_interval_us <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SCREEN_WIDTH:   prdata = {23'd0, cfg_q.screen_width};
			REG_SCREEN_HEIGHT:  prdata = {23'd0, cfg_q.screen_height};
			REG_FRAME_INTERVAL: prdata = {12'd0, cfg_q.frame_interval_us};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/rbd_agu.sv =====
module rbd_agu #(
	parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF,
	parameter int AW        = 16
) (
	input  rbd_pkg::agu_req_t req,
	output logic [AW-1:0]     addr
);

	localparam int PW = AW + 10;

	logic [9:0]    row;
	logic [9:0]    col;
	logic [PW-1:0] lin;

	assign row  = {1'b0, req.base_y} + {1'b0, req.off_y};
	assign col  = {1'b0, req.base_x} + {1'b0, req.off_x};
	assign lin  = PW'(row) * PW'(MAX_WIDTH) + PW'(col);
	assign addr = lin[AW-1:0];

endmodule

// ===== src/rbd_pixel_mem.sv =====
module rbd_pixel_mem #(
	parameter int DEPTH = rbd_pkg::MAX_WIDTH_DEF * rbd_pkg::MAX_HEIGHT_DEF,
	parameter int AW    = 16
) (
	input  logic              clk,
	input  rbd_pkg::mem_req_t req,
	input  logic [AW-1:0]     addr,
	output logic [23:0]       rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== src/rbd_seq.sv =====
module rbd_seq #(
	parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT_DEF,
	parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
	parameter int AW         = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rbd_pkg::cmd_t      cmd,
	output logic               done,
	output rbd_pkg::rsp_t      rsp,
	input  rbd_pkg::cfg_t      cfg,
	output rbd_pkg::agu_req_t  agu_req,
	input  logic [AW-1:0]      agu_addr,
	output rbd_pkg::mem_req_t  mem_req,
	output logic [AW-1:0]      mem_addr,
	input  logic [23:0]        mem_rdata
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_FILL,
		S_RD,
		S_WR,
		S_RESP
	} state_t;

	state_t        state_q;
	rbd_pkg::cmd_t cmd_q;
	rbd_pkg::rsp_t rsp_q;
	logic          done_q;
	logic [AW-1:0] clr_q;
	logic [8:0]    ro_q, co_q, rw_q, rh_q;
	logic          xback_q, yback_q;
	logic          pend_q;
	logic [8:0]    dmg_l_q, dmg_t_q, dmg_r_q, dmg_b_q;
	logic [47:0]   last_q;

	logic [9:0]    eff_w, eff_h;
	logic          fit_dst, fit_src, fit_pix;
	logic          col_last, row_last;
	logic [8:0]    col_next, row_next, col_first;
	logic [8:0]    mk_w, mk_h, mk_r, mk_b;
	logic [8:0]    nl, nt, nr, nb;
	logic [47:0]   elapsed;
	logic          tick_ok;
	logic          use_src;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_comb begin
		if (32'(cfg.screen_width) > MAX_WIDTH) begin
			eff_w = 10'(MAX_WIDTH);
		end else begin
			eff_w = {1'b0, cfg.screen_width};
		end
		if (32'(cfg.screen_height) > MAX_HEIGHT) begin
			eff_h = 10'(MAX_HEIGHT);
		end else begin
			eff_h = {1'b0, cfg.screen_height};
		end
	end

	assign fit_dst = ({1'b0, cmd_q.dst_x} + {1'b0, cmd_q.rect_width} <= eff_w) &&
		({1'b0, cmd_q.dst_y} + {1'b0, cmd_q.rect_height} <= eff_h);
	assign fit_src = ({1'b0, cmd_q.src_x} + {1'b0, cmd_q.rect_width} <= eff_w) &&
		({1'b0, cmd_q.src_y} + {1'b0, cmd_q.rect_height} <= eff_h);
	assign fit_pix = ({1'b0, cmd_q.dst_x} < eff_w) && ({1'b0, cmd_q.dst_y} < eff_h);

	// The damage box grows by the target rectangle; a pixel write counts as 1x1.
	always_comb begin
		if (cmd_q.op == rbd_pkg::OP_WRITE) begin
			mk_w = 9'd1;
			mk_h = 9'd1;
		end else begin
			mk_w = cmd_q.rect_width;
			mk_h = cmd_q.rect_height;
		end
		mk_r = cmd_q.dst_x + mk_w;
		mk_b = cmd_q.dst_y + mk_h;
		if (!pend_q) begin
			nl = cmd_q.dst_x;
			nt = cmd_q.dst_y;
			nr = mk_r;
			nb = mk_b;
		end else begin
			nl = (cmd_q.dst_x < dmg_l_q) ? cmd_q.dst_x : dmg_l_q;
			nt = (cmd_q.dst_y < dmg_t_q) ? cmd_q.dst_y : dmg_t_q;
			nr = (mk_r > dmg_r_q) ? mk_r : dmg_r_q;
			nb = (mk_b > dmg_b_q) ? mk_b : dmg_b_q;
		end
	end

	assign elapsed = cmd_q.now_us - last_q;
	assign tick_ok = pend_q && (elapsed >= {28'd0, cfg.frame_interval_us});

	assign col_last  = xback_q ? (co_q == 9'd0) : (co_q == rw_q - 9'd1);
	assign row_last  = yback_q ? (ro_q == 9'd0) : (ro_q == rh_q - 9'd1);
	assign col_next  = xback_q ? co_q - 9'd1 : co_q + 9'd1;
	assign row_next  = yback_q ? ro_q - 9'd1 : ro_q + 9'd1;
	assign col_first = xback_q ? rw_q - 9'd1 : 9'd0;

	assign use_src = (state_q == S_RD) && (cmd_q.op == rbd_pkg::OP_COPY);

	always_comb begin
		agu_req.base_x = use_src ? cmd_q.src_x : cmd_q.dst_x;
		agu_req.base_y = use_src ? cmd_q.src_y : cmd_q.dst_y;
		agu_req.off_x  = co_q;
		agu_req.off_y  = ro_q;
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.wdata = cmd_q.color;
		mem_addr      = agu_addr;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = 24'd0;
				mem_addr      = clr_q;
			end
			S_FILL: begin
				mem_req.we = 1'b1;
			end
			S_RD: begin
				mem_req.re = 1'b1;
			end
			S_WR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cmd_q   <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
			ro_q    <= '0;
			co_q    <= '0;
			rw_q    <= '0;
			rh_q    <= '0;
			xback_q <= 1'b0;
			yback_q <= 1'b0;
			pend_q  <= 1'b0;
			dmg_l_q <= '0;
			dmg_t_q <= '0;
			dmg_r_q <= '0;
			dmg_b_q <= '0;
			last_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					rsp_q   <= '0;
					state_q <= S_IDLE;
					xback_q <= 1'b0;
					yback_q <= 1'b0;
					ro_q    <= '0;
					co_q    <= '0;
					rw_q    <= cmd_q.rect_width;
					rh_q    <= cmd_q.rect_height;
					unique case (cmd_q.op)
						rbd_pkg::OP_FILL: begin
							if (!fit_dst) begin
								rsp_q.status <= 1'b1;
								done_q       <= 1'b1;
							end else begin
								pend_q  <= 1'b1;
								dmg_l_q <= nl;
								dmg_t_q <= nt;
								dmg_r_q <= nr;
								dmg_b_q <= nb;
								if (cmd_q.rect_width == 9'd0 || cmd_q.rect_height == 9'd0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_FILL;
								end
							end
						end
						rbd_pkg::OP_COPY: begin
							if (!fit_dst || !fit_src) begin
								rsp_q.status <= 1'b1;
								done_q       <= 1'b1;
							end else begin
								pend_q  <= 1'b1;
								dmg_l_q <= nl;
								dmg_t_q <= nt;
								dmg_r_q <= nr;
								dmg_b_q <= nb;
								xback_q <= cmd_q.dst_x > cmd_q.src_x;
								yback_q <= cmd_q.dst_y > cmd_q.src_y;
								if (cmd_q.dst_x > cmd_q.src_x) begin
									co_q <= cmd_q.rect_width - 9'd1;
								end
								if (cmd_q.dst_y > cmd_q.src_y) begin
									ro_q <= cmd_q.rect_height - 9'd1;
								end
								if (cmd_q.rect_width == 9'd0 || cmd_q.rect_height == 9'd0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_RD;
								end
							end
						end
						rbd_pkg::OP_WRITE: begin
							rw_q <= 9'd1;
							rh_q <= 9'd1;
							if (!fit_pix) begin
								rsp_q.status <= 1'b1;
								done_q       <= 1'b1;
							end else begin
								pend_q  <= 1'b1;
								dmg_l_q <= nl;
								dmg_t_q <= nt;
								dmg_r_q <= nr;
								dmg_b_q <= nb;
								state_q <= S_FILL;
							end
						end
						rbd_pkg::OP_READ: begin
							if (!fit_pix) begin
								rsp_q.status <= 1'b1;
								done_q       <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
						rbd_pkg::OP_TICK: begin
							done_q <= 1'b1;
							if (tick_ok) begin
								last_q               <= cmd_q.now_us;
								pend_q               <= 1'b0;
								rsp_q.present        <= 1'b1;
								rsp_q.present_x      <= dmg_l_q;
								rsp_q.present_y      <= dmg_t_q;
								rsp_q.present_width  <= dmg_r_q - dmg_l_q;
								rsp_q.present_height <= dmg_b_q - dmg_t_q;
							end
						end
						default: begin
							done_q <= 1'b1;
						end
					endcase
				end
				S_FILL, S_WR: begin
					if (col_last) begin
						co_q <= col_first;
						if (row_last) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ro_q <= row_next;
							if (state_q == S_WR) begin
								state_q <= S_RD;
							end
						end
					end else begin
						co_q <= col_next;
						if (state_q == S_WR) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (cmd_q.op == rbd_pkg::OP_COPY) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					rsp_q.read_color <= mem_rdata;
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/rect_blitter_with_damage_core.sv =====
// Rectangle blitter with a damage box over a 24-bit pixel store.
// A command word is taken at a rising edge where start is high and busy is
// low; busy stays high until the command's single result has been issued.
// The result is on rsp when done is high for a single cycle, and the
// receiver cannot hold it off; rsp keeps it until the next command is checked.
// Each command is registered and then checked. Tick, rejected commands,
// empty rectangles and unknown opcodes finish at the check; a pixel write
// then writes its one pixel, a pixel read reads it and then responds, a
// fill writes each pixel of the rectangle in turn, and a copy reads and
// then writes each pixel. Each pixel goes through the one address unit
// and the single pixel memory port.
// After reset the pixel store is cleared to black one word per cycle,
// all MAX_WIDTH * MAX_HEIGHT words, with busy held high; configuration
// writes on the APB port are taken at any time, including during the clear.
// Configuration should only change while busy is low.
module rect_blitter_with_damage_core #(
	parameter int MAX_WIDTH  = rbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rbd_pkg::cmd_t cmd,
	output logic          done,
	output rbd_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rbd_pkg::cfg_t     cfg;
	rbd_pkg::agu_req_t agu_req;
	rbd_pkg::mem_req_t mem_req;
	logic [AW-1:0]     agu_addr;
	logic [AW-1:0]     mem_addr;
	logic [23:0]       mem_rdata;

	rbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbd_agu #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_agu (
		.req  (agu_req),
		.addr (agu_addr)
	);

	rbd_pixel_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.addr  (mem_addr),
		.rdata (mem_rdata)
	);

	rbd_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DEPTH      (DEPTH),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg       (cfg),
		.agu_req   (agu_req),
		.agu_addr  (agu_addr),
		.mem_req   (mem_req),
		.mem_addr  (mem_addr),
		.mem_rdata (mem_rdata)
	);

endmodule
